/* design/sdes_pkg.sv */
package sdes_pkg;

	typedef logic [7:0] octet_t;
	typedef logic [3:0] nibble_t;

	typedef enum logic [2:0] {
		MODE_ECB = 3'd0,
		MODE_CBC = 3'd1,
		MODE_CFB = 3'd2,
		MODE_OFB = 3'd3,
		MODE_CTR = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE   = 3'd0,
		REG_KEY1   = 3'd1,
		REG_KEY2   = 3'd2,
		REG_IV     = 3'd3
	} reg_idx_t;

	// permutation tables, 1-based source positions, msb first
	localparam logic [3:0] TAB_IP     [8] = '{4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7};
	localparam logic [3:0] TAB_IP_INV [8] = '{4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6};
	localparam logic [3:0] TAB_EP     [8] = '{4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1};
	localparam logic [3:0] TAB_P4     [4] = '{4'd2, 4'd4, 4'd3, 4'd1};

	// s-boxes flattened as {row, col}
	localparam logic [1:0] BOX_ZERO [16] = '{
		2'd1, 2'd0, 2'd3, 2'd2,
		2'd3, 2'd2, 2'd1, 2'd0,
		2'd0, 2'd2, 2'd1, 2'd3,
		2'd3, 2'd1, 2'd3, 2'd2};
	localparam logic [1:0] BOX_ONE [16] = '{
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd2, 2'd0, 2'd1, 2'd3,
		2'd3, 2'd0, 2'd1, 2'd0,
		2'd2, 2'd1, 2'd0, 2'd3};

	function automatic octet_t perm8(input octet_t v, input logic [3:0] tab [8]);
		octet_t r;
		logic [2:0] idx;
		for (int i = 0; i < 8; i++) begin
			idx = 3'(tab[i] - 4'd1);
			r[7 - i] = v[3'd7 - idx];
		end
		return r;
	endfunction

	function automatic octet_t expand(input nibble_t v);
		octet_t r;
		logic [1:0] idx;
		for (int i = 0; i < 8; i++) begin
			idx = 2'(TAB_EP[i] - 4'd1);
			r[7 - i] = v[2'd3 - idx];
		end
		return r;
	endfunction

	function automatic nibble_t perm4(input nibble_t v);
		nibble_t r;
		logic [1:0] idx;
		for (int i = 0; i < 4; i++) begin
			idx = 2'(TAB_P4[i] - 4'd1);
			r[3 - i] = v[2'd3 - idx];
		end
		return r;
	endfunction

	// row = outer bits, column = inner bits
	function automatic logic [3:0] box_addr(input nibble_t g);
		return {g[3], g[0], g[2], g[1]};
	endfunction

	function automatic octet_t round_f(input octet_t v, input octet_t key);
		octet_t t;
		nibble_t s;
		t = expand(v[3:0]) ^ key;
		s = {BOX_ZERO[box_addr(t[7:4])], BOX_ONE[box_addr(t[3:0])]};
		return {v[7:4] ^ perm4(s), v[3:0]};
	endfunction

	function automatic octet_t sdes_forward_block(input octet_t v, input octet_t k1,
		input octet_t k2);
		octet_t t;
		t = perm8(v, TAB_IP);
		t = round_f(t, k1);
		t = {t[3:0], t[7:4]};
		t = round_f(t, k2);
		return perm8(t, TAB_IP_INV);
	endfunction

endpackage

/* design/sdes_block_cipher_modes.sv */
// channel  | direction | payload (lsb up)                          | marks
// ---------+-----------+-------------------------------------------+-------------------------
// s_axis   | in        | tdata: plain_block, counter_block          | tuser: first_block
// m_axis   | out       | tdata: cipher_block                        | -
// cfg      | in        | cfg_index selects register, cfg_data value | write on cfg_we
//
// one byte per cycle sustained while the output accepts; each block moves from the input register
// to the result register, with the two s-des rounds and mode mixing between them; the chain register
// loads at the same edge as the result register, closing its loop through that logic
// arst_n clears valids, config registers and the chain; no clearing pass
// a stalled output holds the result and blocks the input stage only when both are full
module sdes_block_cipher_modes (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,   // [7:0] plain_block, [15:8] counter_block
	input  logic                 s_axis_tuser,   // [0] first_block
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,   // [7:0] cipher_block
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  sdes_pkg::octet_t     cfg_data
);
	import sdes_pkg::*;

	// configuration
	mode_t  mode_q;
	octet_t key1_q;
	octet_t key2_q;
	octet_t iv_q;

	// chaining state
	octet_t chain_q;

	// input stage
	logic   valid_s1;
	octet_t plain_s1;
	octet_t counter_s1;
	logic   first_s1;

	// result stage
	logic   valid_s2;
	octet_t cipher_s2;

	logic   advance;
	octet_t chain_in;
	octet_t enc_src;
	octet_t enc_out;
	octet_t cipher_d;
	octet_t chain_d;

	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = cipher_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ECB;
			key1_q <= '0;
			key2_q <= '0;
			iv_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: mode_q <= mode_t'(cfg_data[2:0]);
				REG_KEY1: key1_q <= cfg_data;
				REG_KEY2: key2_q <= cfg_data;
				REG_IV:   iv_q   <= cfg_data;
				default:  ;
			endcase
		end
	end

	// first block of a message restarts from the iv
	assign chain_in = first_s1 ? iv_q : chain_q;

	always_comb begin
		case (mode_q)
			MODE_CBC:         enc_src = plain_s1 ^ chain_in;
			MODE_CFB,
			MODE_OFB:         enc_src = chain_in;
			MODE_CTR:         enc_src = counter_s1;
			default:          enc_src = plain_s1;
		endcase
	end

	assign enc_out = sdes_forward_block(enc_src, key1_q, key2_q);

	always_comb begin
		cipher_d = enc_out;
		chain_d  = chain_in;
		case (mode_q)
			MODE_CBC: begin
				chain_d = enc_out;
			end
			MODE_CFB: begin
				cipher_d = plain_s1 ^ enc_out;
				chain_d  = cipher_d;
			end
			MODE_OFB: begin
				cipher_d = plain_s1 ^ enc_out;
				chain_d  = enc_out;
			end
			MODE_CTR: begin
				cipher_d = plain_s1 ^ enc_out;
			end
			default: ;  // ecb and unused codes
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			chain_q  <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					chain_q <= chain_d;
				end
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			plain_s1   <= s_axis_tdata[7:0];
			counter_s1 <= s_axis_tdata[15:8];
			first_s1   <= s_axis_tuser;
		end
		if (advance && valid_s1) begin
			cipher_s2 <= cipher_d;
		end
	end

endmodule

/* verif/sdes_scoreboard_pkg.sv */
`timescale 1ns / 100ps

package sdes_scoreboard_pkg;
	import sdes_pkg::*;

	// substitution boxes as [row][column]
	localparam bit [1:0] SUB_ZERO [4][4] = '{
		'{2'd1, 2'd0, 2'd3, 2'd2}, '{2'd3, 2'd2, 2'd1, 2'd0},
		'{2'd0, 2'd2, 2'd1, 2'd3}, '{2'd3, 2'd1, 2'd3, 2'd2}};
	localparam bit [1:0] SUB_ONE [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd2, 2'd0, 2'd1, 2'd3},
		'{2'd3, 2'd0, 2'd1, 2'd0}, '{2'd2, 2'd1, 2'd0, 2'd3}};

	class cipher_scoreboard;
		bit [2:0] mode = '0;
		octet_t key_one = '0;
		octet_t key_two = '0;
		octet_t iv = '0;
		octet_t chain = '0;
		octet_t cipher_q [$];
		int unsigned fail_count = 0;

		function void write_reg(logic [2:0] idx, octet_t data);
			case (idx)
				REG_MODE: mode = data[2:0];
				REG_KEY1: key_one = data;
				REG_KEY2: key_two = data;
				REG_IV: iv = data;
				default: ;
			endcase
		endfunction

		// table positions count from the msb, here rewritten as vector bits
		function octet_t feistel(octet_t v, octet_t k);
			octet_t mixed;
			bit [1:0] s0;
			bit [1:0] s1;
			nibble_t p;
			mixed = {v[0], v[3], v[2], v[1], v[2], v[1], v[0], v[3]} ^ k;
			s0 = SUB_ZERO[{mixed[7], mixed[4]}][{mixed[6], mixed[5]}];
			s1 = SUB_ONE[{mixed[3], mixed[0]}][{mixed[2], mixed[1]}];
			p = {s0[0], s1[0], s1[1], s0[1]};
			return {v[7:4] ^ p, v[3:0]};
		endfunction

		function octet_t encrypt(octet_t v);
			octet_t t;
			t = {v[6], v[2], v[5], v[7], v[4], v[0], v[3], v[1]};
			t = feistel(t, key_one);
			t = {t[3:0], t[7:4]};
			t = feistel(t, key_two);
			return {t[4], t[7], t[5], t[3], t[1], t[6], t[0], t[2]};
		endfunction

		function void note_input(octet_t plain, octet_t counter, bit first);
			octet_t stream;
			octet_t cipher;
			if (first)
				chain = iv;
			case (mode)
				MODE_CBC: begin
					cipher = encrypt(plain ^ chain);
					chain = cipher;
				end
				MODE_CFB: begin
					cipher = plain ^ encrypt(chain);
					chain = cipher;
				end
				MODE_OFB: begin
					stream = encrypt(chain);
					cipher = plain ^ stream;
					chain = stream;
				end
				MODE_CTR: cipher = plain ^ encrypt(counter);
				default: cipher = encrypt(plain);
			endcase
			cipher_q.push_back(cipher);
		endfunction

		function void check_cipher(octet_t got);
			octet_t want;
			if (cipher_q.size() == 0) begin
				$error("cipher_block: expected nothing, got %02h", got);
				fail_count++;
			end else begin
				want = cipher_q.pop_front();
				if (got !== want) begin
					$error("cipher_block: expected %02h, got %02h", want, got);
					fail_count++;
				end
			end
		endfunction

		function int unsigned pending();
			return cipher_q.size();
		endfunction
	endclass

endpackage

/* verif/sdes_block_cipher_modes_test.sv */
`timescale 1ns / 100ps

module sdes_block_cipher_modes_test;
	import sdes_pkg::*;
	import sdes_scoreboard_pkg::*;

	// mode codes the block treats as ecb, and register indexes it ignores
	localparam bit [2:0] MODE_UNDEF_LO = 3'd5;
	localparam bit [2:0] MODE_UNDEF_HI = 3'd7;
	localparam bit [2:0] REG_SPARE_LO = 3'd4;
	localparam bit [2:0] REG_SPARE_HI = 3'd7;

	// cycles with no transaction on either side before the run is abandoned
	localparam int unsigned IDLE_LIMIT = 1000;
	localparam int unsigned ITEM_TARGET = 1000;
	localparam int unsigned HOLD_CYCLES = 100;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // [7:0] plain_block, [15:8] counter_block
	logic s_axis_tuser = 1'b0;        // [0] first_block
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;         // [7:0] cipher_block
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	octet_t cfg_data = '0;

	cipher_scoreboard sb = new;

	// sender burst state and the receiver hold-off request
	int unsigned burst_left = 0;
	bit hold_off_req = 1'b0;
	int unsigned idle_cycles = 0;

	sdes_block_cipher_modes dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one register write per clock, enable stays high across back-to-back writes
	task automatic set_reg(logic [2:0] idx, octet_t data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
	endtask

	// full register set; upper bits of the mode byte are junk the block must drop
	task automatic configure(bit [2:0] mode, octet_t k1, octet_t k2, octet_t iv, bit spare);
		set_reg(REG_MODE, {5'($urandom_range(0, 31)), mode});
		set_reg(REG_KEY1, k1);
		set_reg(REG_KEY2, k2);
		set_reg(REG_IV, iv);
		// write to an index past the list, must leave every register alone
		if (spare || $urandom_range(0, 3) == 0)
			set_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 8'($urandom));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one block; bursts of random length separated by random gaps
	task automatic send_block(octet_t plain, octet_t counter, bit first);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {counter, plain};
		s_axis_tuser <= first;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(plain, counter, first);
	endtask

	// drop valid in the step of the last transaction, then let the pipe drain
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// extremes now and then, random otherwise
	function automatic octet_t pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// every result transaction is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_cipher(m_axis_tdata);
	end

	// watchdog on transaction-free stretches
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: segments of differing stall patterns, plus one long hold on request
	initial begin
		rx_style_t style;
		int unsigned seg;
		forever begin
			style = rx_style_t'($urandom_range(0, 3));
			seg = $urandom_range(10, 150);
			repeat (seg) begin
				@(posedge clk);
				if (hold_off_req) begin
					m_axis_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_off_req = 1'b0;
				end
				case (style)
					RX_OPEN: m_axis_tready <= 1'b1;
					RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ~m_axis_tready;
				endcase
			end
		end
	end

	initial begin
		mode_t chained [4] = '{MODE_CBC, MODE_CFB, MODE_OFB, MODE_CTR};
		int unsigned total;
		int unsigned sent;
		int unsigned phase;
		int unsigned phase_len;
		int unsigned msg_len;
		octet_t ctr;
		octet_t counter;
		bit first;
		bit [2:0] mode;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// chained mode with no first block yet: chain runs from its reset value
		configure(MODE_CBC, 8'h00, 8'hFF, 8'hA5, 1'b0);
		send_block(8'h00, 8'h00, 1'b0);
		send_block(8'hFF, 8'hFF, 1'b0);
		send_block(8'h5A, 8'hA5, 1'b0);
		drain();

		// ecb with a first block: iv is loaded but has no effect on the result
		configure(MODE_ECB, 8'hFF, 8'h00, 8'h3C, 1'b1);
		send_block(8'h00, 8'hFF, 1'b1);
		send_block(8'hFF, 8'h00, 1'b0);
		send_block(8'h80, 8'h01, 1'b0);
		drain();

		// each feedback mode and ctr, iv at both extremes
		foreach (chained[i]) begin
			configure(chained[i], pick_byte(), pick_byte(), (i % 2) ? 8'hFF : 8'h00, 1'b0);
			send_block(8'h00, 8'h00, 1'b1);
			send_block(8'hFF, 8'hFF, 1'b0);
			send_block(8'($urandom), 8'($urandom), 1'b0);
			drain();
		end

		// undefined mode codes fall back to ecb
		configure(MODE_UNDEF_LO, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
		send_block(8'($urandom), 8'($urandom), 1'b1);
		drain();
		configure(MODE_UNDEF_HI, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
		send_block(8'($urandom), 8'($urandom), 1'b1);
		drain();

		// random phases of well-formed messages with occasional broken first marks
		total = 0;
		phase = 0;
		while (total < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0)
				mode = 3'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
			else
				mode = 3'($urandom_range(MODE_ECB, MODE_CTR));
			configure(mode, pick_byte(), pick_byte(), pick_byte(), 1'b0);

			// one phase runs against a long receiver hold so the input backs up
			if (phase == 2)
				hold_off_req = 1'b1;
			phase_len = (phase == 2) ? 80 : $urandom_range(20, 80);

			sent = 0;
			while (sent < phase_len) begin
				msg_len = $urandom_range(1, 16);
				ctr = 8'($urandom);
				for (int j = 0; j < msg_len; j++) begin
					first = (j == 0);
					if ($urandom_range(0, 19) == 0)
						first = !first;
					// counter mostly runs up, wrapping, with stray values mixed in
					counter = ($urandom_range(0, 9) == 0) ? 8'($urandom) : ctr;
					send_block(8'($urandom), counter, first);
					ctr++;
				end
				sent += msg_len;
			end
			total += sent;
			phase++;
			drain();
		end

		repeat (10) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* filelist.f */
design/sdes_pkg.sv
design/sdes_block_cipher_modes.sv
verif/sdes_scoreboard_pkg.sv
verif/sdes_block_cipher_modes_test.sv
